>>> rtl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the Mandelbrot escape-time counter
// Holds the sequencer state type, the control bundle from the sequencer to
// the datapath, and the default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package met_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 28;
  localparam int IN_BITS       = 32;
  localparam int COUNT_BITS    = 16;

  localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = 16'd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MXY,
    ST_MXX,
    ST_MYY,
    ST_MSQ,
    ST_DONE
  } met_state_t;

  typedef struct packed {
    logic start;
    logic step_xy;
    logic step_xx;
    logic step_yy;
    logic step_sq;
  } met_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/met_datapath.sv
// ----------------------------------------------------------------------------
// met_datapath: z register file and shared multiplier
// Holds z, its squares and the point c; one signed multiplier is reused for
// z_real*z_imag, z_real^2 and z_imag^2 under control of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module met_datapath #(
  parameter int WORD_BITS = met_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire met_pkg::met_ctrl_t                  ctrl,
  input  wire logic signed [met_pkg::IN_BITS-1:0]  c_real_i,
  input  wire logic signed [met_pkg::IN_BITS-1:0]  c_imag_i,
  output logic                                     escaped_o
);

  localparam int W    = WORD_BITS;
  localparam int SQ   = 2 * WORD_BITS - FRAC_BITS;
  localparam int EXT  = (WORD_BITS > met_pkg::IN_BITS) ? WORD_BITS : met_pkg::IN_BITS;
  localparam int ACC  = ((SQ > W) ? SQ : W) + 2;
  localparam int PW   = 2 * W;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [SQ:0]         FOUR = {{SQ{1'b0}}, 1'b1} << (FRAC_BITS + 2);

  logic signed [W-1:0]  zr_r, zi_r, cr_r, ci_r;
  logic signed [SQ-1:0] zrsq_r, zisq_r;
  logic signed [PW-1:0] p_r;

  logic signed [EXT-1:0] cr_ext, ci_ext;
  logic signed [W-1:0]   cr_in, ci_in;
  logic signed [ACC-1:0] zr_sum;
  logic signed [W-1:0]   zr_new;
  logic signed [PW:0]    zi_sum;
  logic signed [W-1:0]   zi_new;
  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]  prod;
  logic        [SQ:0]    mag;

  always_comb begin
    cr_ext = EXT'(c_real_i);
    ci_ext = EXT'(c_imag_i);
    if (cr_ext > EXT'(WMAX)) begin
      cr_in = WMAX;
    end else if (cr_ext < EXT'(WMIN)) begin
      cr_in = WMIN;
    end else begin
      cr_in = cr_ext[W-1:0];
    end
    if (ci_ext > EXT'(WMAX)) begin
      ci_in = WMAX;
    end else if (ci_ext < EXT'(WMIN)) begin
      ci_in = WMIN;
    end else begin
      ci_in = ci_ext[W-1:0];
    end

    zr_sum = ACC'(zrsq_r) - ACC'(zisq_r) + ACC'(cr_r);
    if (zr_sum > ACC'(WMAX)) begin
      zr_new = WMAX;
    end else if (zr_sum < ACC'(WMIN)) begin
      zr_new = WMIN;
    end else begin
      zr_new = zr_sum[W-1:0];
    end

    zi_sum = (PW+1)'(p_r >>> (FRAC_BITS - 1)) + (PW+1)'(ci_r);
    if (zi_sum > (PW+1)'(WMAX)) begin
      zi_new = WMAX;
    end else if (zi_sum < (PW+1)'(WMIN)) begin
      zi_new = WMIN;
    end else begin
      zi_new = zi_sum[W-1:0];
    end

    mul_a = ctrl.step_yy ? zi_r : zr_r;
    mul_b = ctrl.step_xy ? zi_r : (ctrl.step_xx ? zr_r : zi_r);
    prod  = mul_a * mul_b;

    mag       = {1'b0, zrsq_r} + {1'b0, zisq_r};
    escaped_o = (mag > FOUR);
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      zr_r   <= '0;
      zi_r   <= '0;
      zrsq_r <= '0;
      zisq_r <= '0;
      cr_r   <= cr_in;
      ci_r   <= ci_in;
    end
    if (ctrl.step_xy) begin
      zr_r <= zr_new;
      p_r  <= prod;
    end
    if (ctrl.step_xx) begin
      zi_r <= zi_new;
      p_r  <= prod;
    end
    if (ctrl.step_yy) begin
      zrsq_r <= p_r[PW-1:FRAC_BITS];
      p_r    <= prod;
    end
    if (ctrl.step_sq) begin
      zisq_r <= p_r[PW-1:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mandelbrot_escape_time_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top: fixed-point Mandelbrot escape-time counter
// Takes one point c per beat, iterates z = z*z + c from zero and returns the
// iteration count at escape (|z|^2 above 4.0) or at the configured limit.
// ----------------------------------------------------------------------------
// Each iteration of a point runs the single shared multiplier three times
// (z_real*z_imag, z_real^2, z_imag^2), spends a state storing z_imag^2 and
// a state on the escape and limit test. The input stalls while a point is in
// work; a finished count sits in the output register, so the next point is
// taken while that count waits to be picked up.
`default_nettype none

module mandelbrot_escape_time_top #(
  parameter int WORD_BITS = met_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [met_pkg::IN_BITS-1:0]     in_c_real,
  input  wire logic signed [met_pkg::IN_BITS-1:0]     in_c_imag,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic             [met_pkg::COUNT_BITS-1:0]  out_iteration_count,
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [met_pkg::COUNT_BITS-1:0]  cfg_wr_data
);

  met_pkg::met_state_t state_r, state_nxt;
  met_pkg::met_ctrl_t  ctrl;

  logic [met_pkg::COUNT_BITS-1:0] max_r;
  logic [met_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [met_pkg::COUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic                           escaped;

  met_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .c_real_i  (in_c_real),
    .c_imag_i  (in_c_imag),
    .escaped_o (escaped)
  );

  assign in_stall            = (state_r != met_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_count_nxt = out_count_r;
    out_valid_nxt = out_valid_r & out_stall;
    ctrl          = '0;
    case (state_r)
      met_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctrl.start = 1'b1;
          count_nxt  = '0;
          state_nxt  = met_pkg::ST_TEST;
        end
      end
      met_pkg::ST_TEST: begin
        if ((count_r < max_r) && !escaped) begin
          state_nxt = met_pkg::ST_MXY;
        end else begin
          state_nxt = met_pkg::ST_DONE;
        end
      end
      met_pkg::ST_MXY: begin
        ctrl.step_xy = 1'b1;
        state_nxt    = met_pkg::ST_MXX;
      end
      met_pkg::ST_MXX: begin
        ctrl.step_xx = 1'b1;
        state_nxt    = met_pkg::ST_MYY;
      end
      met_pkg::ST_MYY: begin
        ctrl.step_yy = 1'b1;
        state_nxt    = met_pkg::ST_MSQ;
      end
      met_pkg::ST_MSQ: begin
        ctrl.step_sq = 1'b1;
        count_nxt    = count_r + 1'b1;
        state_nxt    = met_pkg::ST_TEST;
      end
      met_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = met_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = met_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= met_pkg::ST_IDLE;
      max_r       <= met_pkg::MAX_ITER_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
  end

endmodule

`default_nettype wire

>>> tb/sv/mandelbrot_escape_time_top_test.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top_test: regression for the escape-time counter
// Feeds points of the complex plane through the valid/stall input channel and
// checks every iteration count against a known table value or a fixed-point
// predictor of z = z*z + c. A directed table covers the field extremes, the
// zero and full-scale limits, the inclusive escape test and floor rounding;
// random points near the set boundary and random noise follow under several
// iteration limits, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_top_test;

  localparam int W      = met_pkg::WORD_BITS_DEF;
  localparam int F      = met_pkg::FRAC_BITS_DEF;
  localparam int SQ_W   = 2 * W - F;
  localparam int CNT_W  = met_pkg::COUNT_BITS;
  localparam int TAIL   = 20;

  localparam logic signed [63:0] FOUR = 64'sd1 <<< (F + 2);

  localparam logic signed [31:0] ZERO      = 32'sh0000_0000;
  localparam logic signed [31:0] TWO       = 32'sh2000_0000;
  localparam logic signed [31:0] NEG_TWO   = 32'shE000_0000;
  localparam logic signed [31:0] NEG_ONE   = 32'shF000_0000;
  localparam logic signed [31:0] FIELD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FIELD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] PLUS_LSB  = 32'sh0000_0001;
  localparam logic signed [31:0] MINUS_LSB = 32'shFFFF_FFFF;
  localparam logic signed [31:0] RE_LO     = 32'shD800_0000;
  localparam logic signed [31:0] IM_LO     = 32'shE800_0000;
  localparam int unsigned        RE_SPAN   = 939524096;
  localparam int unsigned        IM_SPAN   = 805306368;

  localparam logic [CNT_W-1:0] LIMIT_ZERO = '0;
  localparam logic [CNT_W-1:0] LIMIT_FULL = '1;

  typedef struct packed {
    logic [CNT_W-1:0]   limit;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic               known;
    logic [CNT_W-1:0]   count;
  } point_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [met_pkg::IN_BITS-1:0] in_c_real;
  logic signed [met_pkg::IN_BITS-1:0] in_c_imag;
  logic                          out_valid;
  logic                          out_stall;
  logic [CNT_W-1:0]              out_iteration_count;
  logic                          cfg_wr_en;
  logic [CNT_W-1:0]              cfg_wr_data;

  logic [CNT_W-1:0] expected_counts[$];
  logic [CNT_W-1:0] popped_count;
  logic [CNT_W-1:0] iter_limit;
  point_row_t       point_table[$];
  int               error_count;

  mandelbrot_escape_time_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_c_real           (in_c_real),
    .in_c_imag           (in_c_imag),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_iteration_count (out_iteration_count),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic signed [63:0] clamp_bits(logic signed [63:0] v, int bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] escape_count(logic signed [31:0] cr,
                                                    logic signed [31:0] ci,
                                                    logic [CNT_W-1:0] limit);
    logic signed [W-1:0] zr;
    logic signed [W-1:0] zi;
    logic signed [63:0]  zr_sq;
    logic signed [63:0]  zi_sq;
    logic signed [63:0]  prod;
    int                  n;
    zr = '0;
    zi = '0;
    zr_sq = '0;
    zi_sq = '0;
    n = 0;
    while (n < int'(limit) && zr_sq + zi_sq <= FOUR) begin
      prod = zr * zi;
      prod = prod >>> (F - 1);
      zi = W'(clamp_bits(prod + ci, W));
      zr = W'(clamp_bits(zr_sq - zi_sq + cr, W));
      prod = zr * zr;
      zr_sq = clamp_bits(prod >>> F, SQ_W);
      prod = zi * zi;
      zi_sq = clamp_bits(prod >>> F, SQ_W);
      n++;
    end
    return CNT_W'(n);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic add_row(logic [CNT_W-1:0] limit, logic signed [31:0] cr,
                         logic signed [31:0] ci, bit known, logic [CNT_W-1:0] count);
    point_row_t row;
    row.limit  = limit;
    row.c_real = cr;
    row.c_imag = ci;
    row.known  = known;
    row.count  = count;
    point_table.push_back(row);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_counts.size() != 0) @(negedge clk);
  endtask

  task automatic set_limit(logic [CNT_W-1:0] limit);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    iter_limit = limit;
  endtask

  task automatic send_point(logic signed [31:0] cr, logic signed [31:0] ci,
                            bit known, logic [CNT_W-1:0] count, int gap);
    logic [CNT_W-1:0] want;
    want = known ? count : escape_count(cr, ci, iter_limit);
    in_valid  <= 1'b1;
    in_c_real <= cr;
    in_c_imag <= ci;
    do @(posedge clk); while (in_stall);
    expected_counts.push_back(want);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $error("iteration_count: expected none, actual %0d", out_iteration_count);
        error_count++;
      end else begin
        popped_count = expected_counts.pop_front();
        if (out_iteration_count !== popped_count) begin
          $error("iteration_count: expected %0d, actual %0d",
                 popped_count, out_iteration_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    int run;
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      repeat (run) @(negedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(8 * 10_000_000);
    $display("mandelbrot_escape_time_top regression: fail");
    $finish;
  end

  initial begin
    logic signed [31:0] cr;
    logic signed [31:0] ci;
    logic [CNT_W-1:0]   limit;
    bit                 quiet;
    error_count = 0;
    iter_limit  = met_pkg::MAX_ITER_RESET;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_c_real   = '0;
    in_c_imag   = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;

    add_row(16'd4096, ZERO, ZERO, 1'b1, 16'd4096);
    add_row(16'd4096, NEG_TWO, ZERO, 1'b1, 16'd4096);
    add_row(16'd4096, FIELD_MAX, FIELD_MAX, 1'b1, 16'd1);
    add_row(16'd4096, FIELD_MIN, FIELD_MIN, 1'b1, 16'd1);
    add_row(16'd4096, FIELD_MIN, FIELD_MAX, 1'b1, 16'd1);
    add_row(16'd4096, ZERO, FIELD_MIN, 1'b1, 16'd1);
    add_row(16'd4096, FIELD_MAX, ZERO, 1'b1, 16'd1);
    add_row(16'd4096, TWO, ZERO, 1'b0, '0);
    add_row(16'd4096, 32'sh1000_0000, 32'sh1000_0000, 1'b0, '0);
    add_row(LIMIT_ZERO, ZERO, ZERO, 1'b1, 16'd0);
    add_row(LIMIT_ZERO, FIELD_MAX, FIELD_MIN, 1'b1, 16'd0);
    add_row(LIMIT_ZERO, NEG_TWO, ZERO, 1'b1, 16'd0);
    add_row(16'd1, ZERO, ZERO, 1'b1, 16'd1);
    add_row(16'd1, MINUS_LSB, MINUS_LSB, 1'b1, 16'd1);
    add_row(16'd1, FIELD_MAX, FIELD_MAX, 1'b1, 16'd1);
    add_row(16'd255, 32'shF400_0000, 32'sh0199_999A, 1'b0, '0);
    add_row(16'd255, 32'sh0400_0000, ZERO, 1'b0, '0);
    add_row(16'd255, NEG_ONE, ZERO, 1'b0, '0);
    add_row(16'd255, 32'sh0600_0000, 32'sh0A00_0000, 1'b0, '0);
    add_row(16'd255, MINUS_LSB, PLUS_LSB, 1'b0, '0);
    add_row(LIMIT_FULL, ZERO, ZERO, 1'b1, 16'd65535);
    add_row(LIMIT_FULL, 32'sh0500_0000, ZERO, 1'b0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (point_table[i]) begin
      if (point_table[i].limit != iter_limit) set_limit(point_table[i].limit);
      send_point(point_table[i].c_real, point_table[i].c_imag,
                 point_table[i].known, point_table[i].count, pick_gap());
    end

    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0) limit = 16'd1;
      else if (phase == 3) limit = CNT_W'($urandom_range(2, 8));
      else limit = CNT_W'($urandom_range(16, 300));
      quiet = (phase == 2);
      set_limit(limit);
      for (int k = 0; k < 17; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          cr = $urandom;
          ci = $urandom;
        end else begin
          cr = RE_LO + $urandom_range(0, RE_SPAN);
          ci = IM_LO + $urandom_range(0, IM_SPAN);
        end
        send_point(cr, ci, 1'b0, '0, quiet ? 0 : pick_gap());
        if (!quiet && $urandom_range(0, 15) == 0) drain();
      end
    end

    drain();
    repeat (TAIL) @(negedge clk);
    if (expected_counts.size() != 0) begin
      $error("iteration_count: %0d beats never arrived", expected_counts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("mandelbrot_escape_time_top regression: pass");
    end else begin
      $display("mandelbrot_escape_time_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> mandelbrot_escape_time_top.f
rtl/met_pkg.sv
rtl/met_datapath.sv
rtl/mandelbrot_escape_time_top.sv
tb/sv/mandelbrot_escape_time_top_test.sv
